FILE: sv/cht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// Types, constants and command/status structs shared by the cuckoo hash core.
// ----------------------------------------------------------------------------
package cht_pkg;

  typedef enum logic [1:0] {
    KIND_GET    = 2'd0,
    KIND_PUT    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RSVD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_LEFT_LOW   = 2'd0,
    CFG_LEFT_HIGH  = 2'd1,
    CFG_RIGHT_LOW  = 2'd2,
    CFG_RIGHT_HIGH = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CountBits  = 12;
  localparam int unsigned SipRounds  = 8;  // 2 compression rounds per message word + 4 finalization (64-bit key)

  localparam logic [63:0] SipC0 = 64'h736f6d6570736575;
  localparam logic [63:0] SipC1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SipC2 = 64'h6c7967656e657261;
  localparam logic [63:0] SipC3 = 64'h7465646279746573;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  // one SipRound
  function automatic sip_state_t sip_round(input sip_state_t s);
    sip_state_t r;
    r = s;
    r.v0 = r.v0 + r.v1; r.v1 = {r.v1[50:0], r.v1[63:51]}; r.v1 = r.v1 ^ r.v0;
    r.v0 = {r.v0[31:0], r.v0[63:32]};
    r.v2 = r.v2 + r.v3; r.v3 = {r.v3[47:0], r.v3[63:48]}; r.v3 = r.v3 ^ r.v2;
    r.v0 = r.v0 + r.v3; r.v3 = {r.v3[42:0], r.v3[63:43]}; r.v3 = r.v3 ^ r.v0;
    r.v2 = r.v2 + r.v1; r.v1 = {r.v1[46:0], r.v1[63:47]}; r.v1 = r.v1 ^ r.v2;
    r.v2 = {r.v2[31:0], r.v2[63:32]};
    return r;
  endfunction

  // datapath commands
  typedef struct packed {
    logic hash_start;   // start both hashes on the current key
    logic load_in;      // capture the input item as the carried pair
    logic rd_idx;       // read both tables at the hashed indices
    logic rd_evict;     // read the victim slot on the current side
    logic wr_left;      // write carried pair at left index
    logic wr_right;     // write carried pair at right index
    logic wr_val_only;  // write value only (update)
    logic set_valid;    // set the valid mark with the write
    logic clr_left;     // clear left valid mark at left index
    logic clr_right;    // clear right valid mark at right index
    logic swap;         // carried pair takes the evicted pair
    logic flip_side;
    logic side_init;
    logic cnt_inc;
    logic cnt_dec;
    logic res_load;
    status_e res_status;
    logic res_fval_hit_left;
    logic res_fval_hit_right;
    logic res_homeless;
  } cht_cmd_t;

  typedef struct packed {
    logic init_busy;    // valid marks are still being cleared after reset
    logic hash_done;
    logic in_left;
    logic in_right;
    logic left_valid;
    logic right_valid;
    logic side_left;    // current eviction side is left
    logic cur_free;     // the slot on the current side at its new index is free
  } cht_sts_t;

endpackage
`default_nettype wire

FILE: sv/cht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ram
// Single-port generic RAM with registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

FILE: sv/cht_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_hash
// Iterative SipHash-2-4 over one key, one round per cycle, index reduced
// modulo the table depth.
// ----------------------------------------------------------------------------
module cht_hash #(
  parameter int unsigned KeyBits  = 64,
  parameter int unsigned IdxBits  = 10,
  parameter int unsigned TableDepth = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [KeyBits-1:0] key_i,
  input  wire logic [63:0]        k0_i,
  input  wire logic [63:0]        k1_i,
  output logic                    done_o,
  output logic [IdxBits-1:0]      idx_o
);
  localparam int unsigned KeyBytes = (KeyBits + 7) / 8;
  localparam int unsigned NRounds  = (KeyBytes == 8) ? 8 : 6;
  localparam logic [63:0] LastWord = 64'(KeyBytes) << 56;

  logic [63:0] key64;
  logic [63:0] last;
  cht_pkg::sip_state_t st_q, st_d, rnd;
  logic [3:0] step_q, step_d;
  logic       busy_q, busy_d;
  logic [63:0] hval;

  assign key64 = 64'(key_i);
  assign last  = (KeyBytes == 8) ? LastWord : (LastWord | key64);
  assign rnd   = cht_pkg::sip_round(st_q);
  assign hval  = st_q.v0 ^ st_q.v1 ^ st_q.v2 ^ st_q.v3;

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      st_d.v0 = k0_i ^ cht_pkg::SipC0;
      st_d.v1 = k1_i ^ cht_pkg::SipC1;
      st_d.v2 = k0_i ^ cht_pkg::SipC2;
      st_d.v3 = k1_i ^ cht_pkg::SipC3;
      if (KeyBytes == 8) st_d.v3 = st_d.v3 ^ key64;
      else               st_d.v3 = st_d.v3 ^ last;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      st_d   = rnd;
      // inject message words between round groups
      if (KeyBytes == 8 && step_q == 4'd1) begin
        st_d.v0 = st_d.v0 ^ key64;
        st_d.v3 = st_d.v3 ^ last;
      end
      if (step_q == 4'(NRounds - 5)) begin
        st_d.v0 = st_d.v0 ^ last;
        st_d.v2 = st_d.v2 ^ 64'hff;
      end
      step_d = step_q + 4'd1;
      if (step_q == 4'(NRounds - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_o <= busy_q && (step_q == 4'(NRounds - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign idx_o = IdxBits'(hval % 64'(TableDepth));
endmodule
`default_nettype wire

FILE: sv/cht_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_datapath
// Seeds, hash units, the table RAMs, valid marks, carried pair, count
// and the result register.
// ----------------------------------------------------------------------------
module cht_datapath #(
  parameter int unsigned TableDepth = 1024,
  parameter int unsigned KeyBits    = 64,
  parameter int unsigned ValueBits  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [cht_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic [63:0] in_key_i,
  input  wire logic [63:0] in_val_i,
  input  wire cht_pkg::cht_cmd_t cmd_i,
  output cht_pkg::cht_sts_t sts_o,
  output logic [1:0]  res_status_o,
  output logic [63:0] res_fval_o,
  output logic [63:0] res_hkey_o,
  output logic [11:0] res_total_o
);
  localparam int unsigned IdxBits = $clog2(TableDepth);

  logic [63:0] seed_q [4];
  logic [KeyBits-1:0]   ck_q;
  logic [ValueBits-1:0] cv_q;
  logic side_left_q;
  logic [IdxBits-1:0] li, ri, li_q, ri_q;
  logic ldone, rdone;
  logic [KeyBits-1:0]   lk_rd, rk_rd;
  logic [ValueBits-1:0] lv_rd, rv_rd;
  logic lvld_rd, rvld_rd;
  logic l_kwe, l_vwe, r_kwe, r_vwe;
  logic l_vld_we, r_vld_we, l_vld_wd, r_vld_wd;
  logic [cht_pkg::CountBits-1:0] cnt_q;
  logic [IdxBits-1:0] laddr, raddr;
  logic init_busy_q;
  logic [IdxBits-1:0] clr_q;

  cht_hash #(.KeyBits(KeyBits), .IdxBits(IdxBits), .TableDepth(TableDepth)) u_hl (
    .clk_i, .rst_ni, .start_i(cmd_i.hash_start), .key_i(ck_q),
    .k0_i(seed_q[0]), .k1_i(seed_q[1]), .done_o(ldone), .idx_o(li));
  cht_hash #(.KeyBits(KeyBits), .IdxBits(IdxBits), .TableDepth(TableDepth)) u_hr (
    .clk_i, .rst_ni, .start_i(cmd_i.hash_start), .key_i(ck_q),
    .k0_i(seed_q[2]), .k1_i(seed_q[3]), .done_o(rdone), .idx_o(ri));

  // hold indices once hashes finish
  always_ff @(posedge clk_i) begin
    if (ldone) li_q <= li;
    if (rdone) ri_q <= ri;
  end

  // sweep both valid RAMs to zero after reset
  assign laddr = init_busy_q ? clr_q : li_q;
  assign raddr = init_busy_q ? clr_q : ri_q;
  assign l_kwe = cmd_i.wr_left && !cmd_i.wr_val_only;
  assign l_vwe = cmd_i.wr_left;
  assign r_kwe = cmd_i.wr_right && !cmd_i.wr_val_only;
  assign r_vwe = cmd_i.wr_right;
  assign l_vld_we = init_busy_q || (cmd_i.wr_left && cmd_i.set_valid) || cmd_i.clr_left;
  assign r_vld_we = init_busy_q || (cmd_i.wr_right && cmd_i.set_valid) || cmd_i.clr_right;
  assign l_vld_wd = cmd_i.set_valid && !init_busy_q;
  assign r_vld_wd = cmd_i.set_valid && !init_busy_q;

  cht_ram #(.Width(KeyBits),   .Depth(TableDepth)) u_lk (
    .clk_i, .we_i(l_kwe), .addr_i(laddr), .wdata_i(ck_q), .rdata_o(lk_rd));
  cht_ram #(.Width(ValueBits), .Depth(TableDepth)) u_lv (
    .clk_i, .we_i(l_vwe), .addr_i(laddr), .wdata_i(cv_q), .rdata_o(lv_rd));
  cht_ram #(.Width(1),         .Depth(TableDepth)) u_lvld (
    .clk_i, .we_i(l_vld_we), .addr_i(laddr), .wdata_i(l_vld_wd), .rdata_o(lvld_rd));
  cht_ram #(.Width(KeyBits),   .Depth(TableDepth)) u_rk (
    .clk_i, .we_i(r_kwe), .addr_i(raddr), .wdata_i(ck_q), .rdata_o(rk_rd));
  cht_ram #(.Width(ValueBits), .Depth(TableDepth)) u_rv (
    .clk_i, .we_i(r_vwe), .addr_i(raddr), .wdata_i(cv_q), .rdata_o(rv_rd));
  cht_ram #(.Width(1),         .Depth(TableDepth)) u_rvld (
    .clk_i, .we_i(r_vld_we), .addr_i(raddr), .wdata_i(r_vld_wd), .rdata_o(rvld_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q[0] <= '0; seed_q[1] <= '0; seed_q[2] <= '0; seed_q[3] <= '0;
      cnt_q <= '0;
      side_left_q <= 1'b1;
      init_busy_q <= 1'b1;
      clr_q <= '0;
    end else begin
      if (cfg_we_i) seed_q[cfg_idx_i] <= cfg_data_i;
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 12'd1;
      else if (cmd_i.cnt_dec) cnt_q <= cnt_q - 12'd1;
      if (cmd_i.side_init) side_left_q <= 1'b1;
      else if (cmd_i.flip_side) side_left_q <= !side_left_q;
      if (init_busy_q) begin
        if (clr_q == IdxBits'(TableDepth - 1)) init_busy_q <= 1'b0;
        else clr_q <= clr_q + IdxBits'(1);
      end
    end
  end

  // carried pair: input item or the pair read from the victim slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ck_q <= in_key_i[KeyBits-1:0];
      cv_q <= in_val_i[ValueBits-1:0];
    end else if (cmd_i.swap) begin
      ck_q <= side_left_q ? lk_rd : rk_rd;
      cv_q <= side_left_q ? lv_rd : rv_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_o <= cmd_i.res_status;
      res_fval_o   <= '0;
      res_hkey_o   <= '0;
      if (cmd_i.res_fval_hit_left)  res_fval_o <= 64'(lv_rd);
      if (cmd_i.res_fval_hit_right) res_fval_o <= 64'(rv_rd);
      if (cmd_i.res_homeless) begin
        res_fval_o <= 64'(cv_q);
        res_hkey_o <= 64'(ck_q);
      end
      res_total_o <= cnt_q + {11'd0, cmd_i.cnt_inc} - {11'd0, cmd_i.cnt_dec};
    end
  end

  assign sts_o.init_busy   = init_busy_q;
  assign sts_o.hash_done   = ldone && rdone;
  assign sts_o.left_valid  = lvld_rd;
  assign sts_o.right_valid = rvld_rd;
  assign sts_o.in_left     = lvld_rd && (lk_rd == ck_q);
  assign sts_o.in_right    = rvld_rd && (rk_rd == ck_q);
  assign sts_o.side_left   = side_left_q;
  assign sts_o.cur_free    = side_left_q ? !lvld_rd : !rvld_rd;
endmodule
`default_nettype wire

FILE: sv/cht_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ctrl
// Operation sequencer: hash, read, decide, evict, answer.
// ----------------------------------------------------------------------------
module cht_ctrl #(
  parameter int unsigned MaxKicks = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic [1:0] in_kind_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cht_pkg::cht_cmd_t cmd_o,
  input  wire cht_pkg::cht_sts_t sts_i
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_HASH  = 9'b0_0000_0010,
    S_READ  = 9'b0_0000_0100,
    S_DEC   = 9'b0_0000_1000,
    S_EVRD  = 9'b0_0001_0000,
    S_EVSW  = 9'b0_0010_0000,
    S_EVHSH = 9'b0_0100_0000,
    S_OUT   = 9'b0_1000_0000,
    S_EVDEC = 9'b1_0000_0000
  } state_e;

  localparam int unsigned KickBits = $clog2(MaxKicks + 1);

  state_e state_q, state_d;
  cht_pkg::kind_e kind_q;
  logic [KickBits-1:0] kick_q, kick_d;
  logic rd_wait_q, rd_wait_d;

  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = cht_pkg::STAT_MISS;
    state_d = state_q;
    kick_d  = kick_q;
    rd_wait_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !sts_i.init_busy) begin
          cmd_o.load_in = 1'b1;
          cmd_o.side_init = 1'b1;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash_start = 1'b1;
        state_d = S_READ;
      end
      S_READ: begin
        // wait for index, then for the registered RAM read
        if (sts_i.hash_done) rd_wait_d = 1'b1;
        if (rd_wait_q) state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.res_load = 1'b1;
        state_d = S_OUT;
        case (kind_q)
          cht_pkg::KIND_GET: begin
            if (sts_i.in_left) begin
              cmd_o.res_status = cht_pkg::STAT_OK; cmd_o.res_fval_hit_left = 1'b1;
            end else if (sts_i.in_right) begin
              cmd_o.res_status = cht_pkg::STAT_OK; cmd_o.res_fval_hit_right = 1'b1;
            end
          end
          cht_pkg::KIND_REMOVE: begin
            if (sts_i.in_left) begin
              cmd_o.res_status = cht_pkg::STAT_OK; cmd_o.clr_left = 1'b1;
              cmd_o.cnt_dec = 1'b1;
            end else if (sts_i.in_right) begin
              cmd_o.res_status = cht_pkg::STAT_OK; cmd_o.clr_right = 1'b1;
              cmd_o.cnt_dec = 1'b1;
            end
          end
          cht_pkg::KIND_PUT: begin
            cmd_o.res_status = cht_pkg::STAT_OK;
            if (sts_i.in_left) begin
              cmd_o.wr_left = 1'b1; cmd_o.wr_val_only = 1'b1;
            end else if (sts_i.in_right) begin
              cmd_o.wr_right = 1'b1; cmd_o.wr_val_only = 1'b1;
            end else if (!sts_i.left_valid) begin
              cmd_o.wr_left = 1'b1; cmd_o.set_valid = 1'b1; cmd_o.cnt_inc = 1'b1;
            end else if (!sts_i.right_valid) begin
              cmd_o.wr_right = 1'b1; cmd_o.set_valid = 1'b1; cmd_o.cnt_inc = 1'b1;
            end else begin
              cmd_o.res_load = 1'b0;
              kick_d = '0;
              state_d = S_EVSW;
            end
          end
          default: ;
        endcase
      end
      S_EVSW: begin
        // victim was read on current side: write carried pair there, take victim
        if (sts_i.side_left) cmd_o.wr_left = 1'b1;
        else                 cmd_o.wr_right = 1'b1;
        cmd_o.swap = 1'b1;
        cmd_o.flip_side = 1'b1;
        kick_d = kick_q + KickBits'(1);
        state_d = S_EVHSH;
      end
      S_EVHSH: begin
        cmd_o.hash_start = 1'b1;
        state_d = S_EVRD;
      end
      S_EVRD: begin
        if (sts_i.hash_done) rd_wait_d = 1'b1;
        if (rd_wait_q) state_d = S_EVDEC;
      end
      S_EVDEC: begin
        if (sts_i.cur_free) begin
          if (sts_i.side_left) cmd_o.wr_left = 1'b1;
          else                 cmd_o.wr_right = 1'b1;
          cmd_o.set_valid = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_status = cht_pkg::STAT_OK;
          state_d = S_OUT;
        end else if (kick_q == KickBits'(MaxKicks)) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_status = cht_pkg::STAT_FULL;
          cmd_o.res_homeless = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_EVSW;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kick_q <= '0;
      rd_wait_q <= 1'b0;
      kind_q <= cht_pkg::KIND_GET;
    end else begin
      state_q <= state_d;
      kick_q <= kick_d;
      rd_wait_q <= rd_wait_d;
      if (in_valid_i && in_ready_o) kind_q <= cht_pkg::kind_e'(in_kind_i);
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !sts_i.init_busy;
  assign out_valid_o = (state_q == S_OUT);

  a_out_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("accept and result overlap");
  a_kick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kick_q <= KickBits'(MaxKicks)) else $error("eviction count overrun");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
endmodule
`default_nettype wire

FILE: sv/cuckoo_hash_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cuckoo_hash_table_core
// Two-table cuckoo hash map with SipHash-2-4 bucket selection.
// ----------------------------------------------------------------------------
// One operation at a time. After reset the valid marks are swept to zero, and
// no transfer is accepted until the sweep is done. Get, remove and a direct
// put give their result after two SipHash-2-4 units run one round per cycle
// (eight rounds), then one registered RAM read and a decision state. Each
// eviction of a put adds a swap, a rehash of the displaced key, a read and a
// decision, up to MAX_KICKS of them. A result is held on the output until
// taken; the next item can be accepted in the cycle after that.
module cuckoo_hash_table_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 64,
  parameter int unsigned VALUE_BITS  = 64,
  parameter int unsigned MAX_KICKS   = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // lookup_key[63:0], store_value[127:64]
  input  wire logic [1:0]   s_axis_tuser,  // kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata   // status[1:0], found_value[65:2],
                                           // homeless_key[129:66], entry_total[141:130]
);
  cht_pkg::cht_cmd_t cmd;
  cht_pkg::cht_sts_t sts;
  logic [1:0]  st;
  logic [63:0] fv, hk;
  logic [11:0] tot;

  cht_ctrl #(.MaxKicks(MAX_KICKS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_kind_i(s_axis_tuser), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts));

  cht_datapath #(.TableDepth(TABLE_DEPTH), .KeyBits(KEY_BITS), .ValueBits(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_key_i(s_axis_tdata[63:0]), .in_val_i(s_axis_tdata[127:64]),
    .cmd_i(cmd), .sts_o(sts), .res_status_o(st), .res_fval_o(fv),
    .res_hkey_o(hk), .res_total_o(tot));

  assign m_axis_tdata = {2'b00, tot, hk, fv, st};
endmodule
`default_nettype wire
